// ===== rtl/mlqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Codes, field widths and the command group shared by the scheduler modules.
// ----------------------------------------------------------------------------
package mlqs_pkg;

   // Widths of the request and response fields.
   localparam int LEVEL_W  = 3;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;

   // Largest number of levels that a request can name.
   localparam int LEVEL_SPAN = 2 ** LEVEL_W;

   // Request kinds, carried in the request's tuser bit.
   typedef enum logic {
      ACTION_ADD  = 1'b0,
      ACTION_TAKE = 1'b1
   } action_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // What the queue bookkeeping asks of the id store for one request.
   typedef struct packed {
      logic write;   // append the id at the returned address
      logic read;    // fetch the head id at the returned address
      logic fail;    // level full or out of range on add, or every level empty on take
   } slot_cmd_type;

endpackage

// ===== rtl/mlqs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mlqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mlqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue bookkeeping
// Head, tail and fill count per level, the strict-priority pick for a take,
// and the store address for the chosen slot.
// ----------------------------------------------------------------------------
module mlqs_ctrl #(
   parameter int LEVELS      = 8,
   parameter int LEVEL_DEPTH = 16,
   localparam int NL = (LEVELS < mlqs_pkg::LEVEL_SPAN) ? LEVELS : mlqs_pkg::LEVEL_SPAN,
   localparam int LW = $clog2(NL),
   localparam int AW = $clog2(NL * LEVEL_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         go,
   input  mlqs_pkg::action_type         action,
   input  logic [mlqs_pkg::LEVEL_W-1:0] level,
   output mlqs_pkg::slot_cmd_type       cmd,
   output logic [AW-1:0]                addr,
   output logic [LW-1:0]                sel_level
);

   localparam int PW = $clog2(LEVEL_DEPTH);
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam logic [mlqs_pkg::LEVEL_W:0] NL_V = (mlqs_pkg::LEVEL_W + 1)'(NL);

   logic [PW-1:0] head_ff [NL];
   logic [PW-1:0] head_in [NL];
   logic [PW-1:0] tail_ff [NL];
   logic [PW-1:0] tail_in [NL];
   logic [CW-1:0] count_ff [NL];
   logic [CW-1:0] count_in [NL];

   logic          is_take;
   logic          level_ok;
   logic [LW-1:0] win;
   logic          any;
   logic [LW-1:0] idx;
   logic [PW-1:0] ptr;
   logic [PW-1:0] ptr_next;
   logic          add_ok;

   assign is_take  = (action == mlqs_pkg::ACTION_TAKE);
   assign level_ok = ({1'b0, level} < NL_V);

   // Lowest-numbered non-empty level wins.
   always_comb begin
      win = '0;
      any = 1'b0;
      for (int i = NL - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            win = LW'(i);
            any = 1'b1;
         end
      end
   end

   assign idx      = is_take ? win : level[LW-1:0];
   assign ptr      = is_take ? head_ff[idx] : tail_ff[idx];
   assign ptr_next = (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
   assign add_ok   = level_ok && (count_ff[idx] != CW'(LEVEL_DEPTH));

   assign cmd.write = !is_take && add_ok;
   assign cmd.read  = is_take && any;
   assign cmd.fail  = is_take ? !any : !add_ok;
   assign addr      = AW'(idx) * AW'(LEVEL_DEPTH) + AW'(ptr);
   assign sel_level = idx;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (go && cmd.write) begin
         tail_in[idx]  = ptr_next;
         count_in[idx] = count_ff[idx] + 1'b1;
      end else if (go && cmd.read) begin
         head_in[idx]  = ptr_next;
         count_in[idx] = count_ff[idx] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // A level never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff[idx] <= CW'(LEVEL_DEPTH))
      else $error("level fill count above depth");

   // A take that finds a level must point at a level with entries.
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.read |-> (count_ff[idx] != '0))
      else $error("take picked an empty level");

   // An accepted add that succeeds is seen in the fill count next cycle.
   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      (go && cmd.write) |=> (count_ff[$past(idx)] == $past(count_ff[idx]) + 1'b1))
      else $error("fill count not advanced by add");

endmodule

// ===== rtl/multilevel_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler
// Strict-priority scheduler keeping one FIFO of process ids per level.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                   Contents
//   req       in         req_tvalid/tready/...   add or take request
//   rsp       out        rsp_tvalid/tready/...   one response per request
//
// An add writes its id to the id store in the cycle of acceptance and its
// response is registered at the same edge. A take that finds an entry reads
// the head slot from the store, whose registered read data passes into the
// response register; the request port is held off while that read is in
// flight. A take that finds every level empty is answered like an add,
// without a store read. Sustained rate is one add or empty take per cycle
// while responses are accepted; a successful take blocks new requests until its read is done.
// Reset clears every head, tail and fill count at once; the id store needs
// no clearing, as only slots covered by a fill count are ever read.
// A new request is taken while a response waits only if that response is
// accepted in the same cycle, and never while a take's read is in flight.
//
module multilevel_queue_scheduler #(
   parameter int LEVELS      = 8,
   parameter int LEVEL_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // level [2:0], proc_id [10:3], zero [15:11]
   input  logic        req_tuser,   // action [0]
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_id [7:0], out_level [10:8], zero [15:11]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   // Only levels that a request can name ever hold entries.
   localparam int NL = (LEVELS < mlqs_pkg::LEVEL_SPAN) ? LEVELS : mlqs_pkg::LEVEL_SPAN;
   localparam int LW = $clog2(NL);
   localparam int AW = $clog2(NL * LEVEL_DEPTH);
   // Ids are kept in their low ID_BITS bits, at most eight, and leave zero-extended to eight.
   localparam int IW = (ID_BITS < mlqs_pkg::ID_W) ? ID_BITS : mlqs_pkg::ID_W;

   mlqs_pkg::action_type         req_action;
   logic [mlqs_pkg::LEVEL_W-1:0] req_level;
   logic [mlqs_pkg::ID_W-1:0]    req_proc_id;
   logic                         accept;

   mlqs_pkg::slot_cmd_type cmd;
   logic [AW-1:0]          slot_addr;
   logic [LW-1:0]          sel_level;
   logic [IW-1:0]          rd_data;

   // The take in flight, waiting for its id from the store.
   logic          pend_ff;
   logic          pend_in;
   logic [LW-1:0] pend_level_ff;

   // Response register.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   mlqs_pkg::status_type         rsp_status_ff;
   mlqs_pkg::status_type         rsp_status_in;
   logic [mlqs_pkg::ID_W-1:0]    rsp_id_ff;
   logic [mlqs_pkg::ID_W-1:0]    rsp_id_in;
   logic [mlqs_pkg::LEVEL_W-1:0] rsp_level_ff;
   logic [mlqs_pkg::LEVEL_W-1:0] rsp_level_in;

   assign req_action  = mlqs_pkg::action_type'(req_tuser);
   assign req_level   = req_tdata[2:0];
   assign req_proc_id = req_tdata[10:3];

   // The store read of a take must not meet a full response register, so
   // nothing is taken while a read is in flight.
   assign req_tready = !pend_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   mlqs_ctrl #(
      .LEVELS      (LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .go        (accept),
      .action    (req_action),
      .level     (req_level),
      .cmd       (cmd),
      .addr      (slot_addr),
      .sel_level (sel_level)
   );

   // Writes and reads never share a cycle, since each request is either an add
   // or a take; no forwarding is needed.
   mlqs_ram #(
      .WIDTH (IW),
      .DEPTH (NL * LEVEL_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && cmd.write),
      .wr_addr (slot_addr),
      .wr_data (req_proc_id[IW-1:0]),
      .rd_en   (accept && cmd.read),
      .rd_addr (slot_addr),
      .rd_data (rd_data)
   );

   assign pend_in = accept && cmd.read;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_level_in  = rsp_level_ff;
      if (pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = mlqs_pkg::STATUS_DONE;
         rsp_id_in     = mlqs_pkg::ID_W'(rd_data);
         rsp_level_in  = mlqs_pkg::LEVEL_W'(pend_level_ff);
      end else if (accept && !cmd.read) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = '0;
         rsp_level_in = '0;
         if (!cmd.fail) begin
            rsp_status_in = mlqs_pkg::STATUS_DONE;
         end else if (req_action == mlqs_pkg::ACTION_TAKE) begin
            rsp_status_in = mlqs_pkg::STATUS_EMPTY;
         end else begin
            rsp_status_in = mlqs_pkg::STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_level_ff <= sel_level;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_level_ff  <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {5'd0, rsp_level_ff, rsp_id_ff};

   // When the store data lands, the response register is free to take it.
   a_pend_slot_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("response register busy when take data arrived");

   // A take that found an entry sets the pending flag and then the response register.
   a_take_answered: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd.read) |=> (pend_ff ##1 rsp_valid_ff))
      else $error("take response not delivered on time");

   // Store writes and reads are never issued together.
   a_one_access: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write && cmd.read))
      else $error("store write and read issued together");

   // Nothing is accepted while a take waits for its data.
   a_hold_off: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !accept)
      else $error("request accepted during a store read");

endmodule
